// ===== rtl/jftc_pkg.sv =====
// shared types and constants for the jump fatigue trend classifier
`timescale 1ns / 1ps
package jftc_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int HELD_W         = 5;
  localparam int LIMIT_W        = 32;
  localparam int RATIO_W        = 16;
  localparam int FLOOR_W        = 16;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 4;
  localparam int WINDOW_DEFAULT = 10;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd3840;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd62259;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 16'd0;

  typedef enum logic [1:0] {
    CODE_UNKNOWN      = 2'd0,
    CODE_INCONCLUSIVE = 2'd1,
    CODE_FATIGUED     = 2'd2,
    CODE_NORMAL       = 2'd3
  } trend_code_t;

  typedef enum logic [1:0] {
    REG_VARIANCE_LIMIT = 2'd0,
    REG_DROP_RATIO     = 2'd1,
    REG_MEAN_FLOOR     = 2'd2
  } reg_index_t;

endpackage

// ===== rtl/jftc_ifs.sv =====
// valid/ready channel interfaces for sample and result words
`timescale 1ns / 1ps
interface jftc_in_if;
  import jftc_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] jump_height;

  modport source (output valid, output jump_height, input ready);
  modport sink (input valid, input jump_height, output ready);
endinterface

interface jftc_out_if;
  import jftc_pkg::*;
  logic              valid;
  logic              ready;
  trend_code_t       trend_code;
  logic [HELD_W-1:0] samples_held;

  modport source (output valid, output trend_code, output samples_held, input ready);
  modport sink (input valid, input trend_code, input samples_held, output ready);
endinterface

// ===== rtl/jftc_front.sv =====
// front end: sample delay line, running sums and sum of squares
`timescale 1ns / 1ps
module jftc_front #(
  parameter int WINDOW = jftc_pkg::WINDOW_DEFAULT
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  jftc_in_if.sink                                       in_word,
  input  logic [$clog2(jftc_pkg::QUEUE_DEPTH+1)-1:0]    q_level,
  output logic                                          push,
  output logic [jftc_pkg::SAMPLE_W+$clog2(WINDOW)-1:0]  push_recent,
  output logic [2*jftc_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] push_square,
  output logic [jftc_pkg::SAMPLE_W+$clog2(WINDOW)-1:0]  push_prior,
  output logic [$clog2(2*WINDOW+1)-1:0]                 push_fill
);
  import jftc_pkg::*;

  localparam int DEPTH = 2 * WINDOW;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
  localparam int SQX_W = 2 * SAMPLE_W;
  localparam int SQ_W  = SQX_W + $clog2(WINDOW);
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  logic [SAMPLE_W-1:0] line_r [DEPTH];
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [SUM_W-1:0]    recent_r, recent_nxt;
  logic [SUM_W-1:0]    prior_r, prior_nxt;
  logic [SQ_W-1:0]     square_r, square_nxt;
  logic [SAMPLE_W-1:0] moving, oldest;
  logic                accept;

  logic                vb_r, vc_r;
  logic [SAMPLE_W-1:0] xb_r, mb_r;
  logic [SUM_W-1:0]    recent_b_r, prior_b_r, recent_c_r, prior_c_r;
  logic [CNT_W-1:0]    fill_b_r, fill_c_r;
  logic [SQX_W-1:0]    sqx_r, sqm_r;
  logic [LVL_W+1:0]    in_flight;

  // credit: every word in flight already owns a queue slot
  assign in_flight     = (LVL_W+2)'(q_level) + (LVL_W+2)'(vb_r) + (LVL_W+2)'(vc_r);
  assign in_word.ready = in_flight < (LVL_W+2)'(QUEUE_DEPTH);
  assign accept        = in_word.valid && in_word.ready;

  assign moving = (fill_r >= CNT_W'(WINDOW)) ? line_r[WINDOW-1] : '0;
  assign oldest = (fill_r == CNT_W'(DEPTH)) ? line_r[DEPTH-1] : '0;

  always_comb begin
    fill_nxt   = (fill_r == CNT_W'(DEPTH)) ? fill_r : fill_r + CNT_W'(1);
    recent_nxt = recent_r + SUM_W'(in_word.jump_height) - SUM_W'(moving);
    prior_nxt  = prior_r + SUM_W'(moving) - SUM_W'(oldest);
    square_nxt = square_r + SQ_W'(sqx_r) - SQ_W'(sqm_r);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_r[0] <= in_word.jump_height;
      for (int i = 1; i < DEPTH; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      recent_r <= '0;
      prior_r  <= '0;
      square_r <= '0;
      vb_r     <= 1'b0;
      vc_r     <= 1'b0;
    end else begin
      vb_r <= accept;
      vc_r <= vb_r;
      if (accept) begin
        fill_r   <= fill_nxt;
        recent_r <= recent_nxt;
        prior_r  <= prior_nxt;
      end
      if (vc_r) begin
        square_r <= square_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      xb_r       <= in_word.jump_height;
      mb_r       <= moving;
      recent_b_r <= recent_nxt;
      prior_b_r  <= prior_nxt;
      fill_b_r   <= fill_nxt;
    end
    if (vb_r) begin
      sqx_r      <= SQX_W'(xb_r) * SQX_W'(xb_r);
      sqm_r      <= SQX_W'(mb_r) * SQX_W'(mb_r);
      recent_c_r <= recent_b_r;
      prior_c_r  <= prior_b_r;
      fill_c_r   <= fill_b_r;
    end
  end

  assign push        = vc_r;
  assign push_recent = recent_c_r;
  assign push_square = square_nxt;
  assign push_prior  = prior_c_r;
  assign push_fill   = fill_c_r;

endmodule

// ===== rtl/jftc_queue.sv =====
// short first-in first-out queue between front and back
`timescale 1ns / 1ps
module jftc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = jftc_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [LVL_W-1:0] level_r;

  assign pop_data  = slot_r[rd_r];
  assign not_empty = level_r != '0;
  assign level     = level_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      level_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      end
      if (push && !pop) begin
        level_r <= level_r + LVL_W'(1);
      end else if (pop && !push) begin
        level_r <= level_r - LVL_W'(1);
      end
    end
  end

endmodule

// ===== rtl/jftc_back.sv =====
// back end: products, threshold compares and the output register
`timescale 1ns / 1ps
module jftc_back #(
  parameter int WINDOW = jftc_pkg::WINDOW_DEFAULT
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           q_valid,
  output logic                                           q_pop,
  input  logic [jftc_pkg::SAMPLE_W+$clog2(WINDOW)-1:0]   q_recent,
  input  logic [2*jftc_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] q_square,
  input  logic [jftc_pkg::SAMPLE_W+$clog2(WINDOW)-1:0]   q_prior,
  input  logic [$clog2(2*WINDOW+1)-1:0]                  q_fill,
  input  logic [jftc_pkg::LIMIT_W-1:0]                   variance_limit,
  input  logic [jftc_pkg::RATIO_W-1:0]                   drop_ratio,
  input  logic [jftc_pkg::FLOOR_W-1:0]                   mean_floor,
  jftc_out_if.source                                     out_word
);
  import jftc_pkg::*;

  localparam int DEPTH   = 2 * WINDOW;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW);
  localparam int SQ_W    = 2 * SAMPLE_W + $clog2(WINDOW);
  localparam int NSQ_W   = SQ_W + $clog2(WINDOW + 1);
  localparam int S1SQ_W  = 2 * SUM_W;
  localparam int NN1     = WINDOW * (WINDOW - 1);
  localparam int BND_W   = LIMIT_W + $clog2(NN1 + 1);
  localparam int CMP_W   = (NSQ_W > BND_W) ? NSQ_W : BND_W;
  localparam int FLR_W   = FLOOR_W + $clog2(WINDOW + 1);
  localparam int DRP_W   = SUM_W + RATIO_W;

  logic              v1_r, adv1;
  logic [NSQ_W-1:0]  nsq_r, spread;
  logic [S1SQ_W-1:0] s1sq_r;
  logic [BND_W-1:0]  bnd_r;
  logic [FLR_W-1:0]  flr_r;
  logic [DRP_W-1:0]  drp_r, rec_sh_r;
  logic [SUM_W-1:0]  prior1_r;
  logic              full1_r;
  logic [HELD_W-1:0] held1_r;

  logic              out_valid_r;
  trend_code_t       code_r, code_nxt;
  logic [HELD_W-1:0] held_r;

  assign adv1  = v1_r && (!out_valid_r || out_word.ready);
  assign q_pop = q_valid && (!v1_r || adv1);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      nsq_r    <= NSQ_W'(q_square) * NSQ_W'(WINDOW);
      s1sq_r   <= S1SQ_W'(q_recent) * S1SQ_W'(q_recent);
      bnd_r    <= BND_W'(variance_limit) * BND_W'(NN1);
      flr_r    <= FLR_W'(mean_floor) * FLR_W'(WINDOW);
      drp_r    <= DRP_W'(q_prior) * DRP_W'(drop_ratio);
      rec_sh_r <= {q_recent, {RATIO_W{1'b0}}};
      prior1_r <= q_prior;
      full1_r  <= q_fill == CNT_W'(DEPTH);
      held1_r  <= HELD_W'(q_fill);
    end
  end

  assign spread = nsq_r - NSQ_W'(s1sq_r);

  always_comb begin
    if (!full1_r) begin
      code_nxt = CODE_UNKNOWN;
    end else if (CMP_W'(spread) > CMP_W'(bnd_r)) begin
      code_nxt = CODE_INCONCLUSIVE;
    end else if (FLR_W'(prior1_r) <= flr_r) begin
      code_nxt = CODE_UNKNOWN;
    end else if (rec_sh_r < drp_r) begin
      code_nxt = CODE_FATIGUED;
    end else begin
      code_nxt = CODE_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        v1_r <= 1'b1;
      end else if (adv1) begin
        v1_r <= 1'b0;
      end
      if (adv1) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      code_r <= code_nxt;
      held_r <= held1_r;
    end
  end

  assign out_word.valid        = out_valid_r;
  assign out_word.trend_code   = code_r;
  assign out_word.samples_held = held_r;

endmodule

// ===== rtl/jump_fatigue_trend_classifier_core.sv =====
// top level of the jump fatigue trend classifier with its register port
`timescale 1ns / 1ps
// Takes one jump-height word per cycle while a queue slot is unclaimed and returns one trend code
// per word, in order, with the count of samples held. A sample passes the front delay line and
// sum-of-squares pipe, the queue, the product stage and the output register; the sustained
// rate is one word per clock while the receiver takes every result. A four-entry queue
// decouples the front from the back, so the input keeps flowing while a result waits, until
// all four slots are claimed. Line entries not yet written are masked by the fill count, so
// no clearing pass follows reset. Registers: 0x0 variance limit, 0x4 drop ratio, 0x8 mean
// floor; write them only while no word is in flight.
module jump_fatigue_trend_classifier_core #(
  parameter int WINDOW = jftc_pkg::WINDOW_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  jftc_in_if.sink                         in_word,
  jftc_out_if.source                      out_word,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [jftc_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [jftc_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [jftc_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import jftc_pkg::*;

  localparam int CNT_W   = $clog2(2 * WINDOW + 1);
  localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW);
  localparam int SQ_W    = 2 * SAMPLE_W + $clog2(WINDOW);
  localparam int ENTRY_W = SUM_W + SQ_W + SUM_W + CNT_W;
  localparam int LVL_W   = $clog2(QUEUE_DEPTH + 1);

  logic [LIMIT_W-1:0] limit_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [FLOOR_W-1:0] floor_r;
  logic               cfg_write;
  reg_index_t         cfg_index;

  logic               push, pop, q_valid;
  logic [SUM_W-1:0]   push_recent, push_prior, q_recent, q_prior;
  logic [SQ_W-1:0]    push_square, q_square;
  logic [CNT_W-1:0]   push_fill, q_fill;
  logic [ENTRY_W-1:0] push_data, pop_data;
  logic [LVL_W-1:0]   q_level;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_index  = reg_index_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      ratio_r <= RATIO_RESET;
      floor_r <= FLOOR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VARIANCE_LIMIT: limit_r <= cfg_pwdata;
        REG_DROP_RATIO:     ratio_r <= cfg_pwdata[RATIO_W-1:0];
        REG_MEAN_FLOOR:     floor_r <= cfg_pwdata[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_VARIANCE_LIMIT: cfg_prdata = limit_r;
      REG_DROP_RATIO:     cfg_prdata = APB_DATA_W'(ratio_r);
      REG_MEAN_FLOOR:     cfg_prdata = APB_DATA_W'(floor_r);
      default:            cfg_prdata = '0;
    endcase
  end

  jftc_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_word),
    .q_level     (q_level),
    .push        (push),
    .push_recent (push_recent),
    .push_square (push_square),
    .push_prior  (push_prior),
    .push_fill   (push_fill)
  );

  assign push_data = {push_recent, push_square, push_prior, push_fill};
  assign {q_recent, q_square, q_prior, q_fill} = pop_data;

  jftc_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_valid),
    .level     (q_level)
  );

  jftc_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_pop          (pop),
    .q_recent       (q_recent),
    .q_square       (q_square),
    .q_prior        (q_prior),
    .q_fill         (q_fill),
    .variance_limit (limit_r),
    .drop_ratio     (ratio_r),
    .mean_floor     (floor_r),
    .out_word       (out_word)
  );

endmodule

// ===== test/jftc_trend_checker.sv =====
// checker for the trend classifier: tracks registers, predicts each trend word and compares
`timescale 1ns / 1ps
module jftc_trend_checker #(
  parameter int WINDOW = jftc_pkg::WINDOW_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  jftc_in_if                              in_mon,
  jftc_out_if                             out_mon,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [jftc_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [jftc_pkg::APB_DATA_W-1:0] cfg_pwdata,
  input  logic                            cfg_pready,
  output int                              fail_count,
  output int                              pending_count
);
  import jftc_pkg::*;

  localparam int LINE_DEPTH = 2 * WINDOW;

  typedef struct packed {
    trend_code_t       code;
    logic [HELD_W-1:0] held;
  } trend_result_t;

  logic [LIMIT_W-1:0]  var_limit;
  logic [RATIO_W-1:0]  drop_ratio;
  logic [FLOOR_W-1:0]  mean_floor;

  logic [SAMPLE_W-1:0] sample_line [LINE_DEPTH];
  int unsigned         line_ptr;
  int unsigned         fill_count;
  logic [19:0]         recent_sum;
  logic [35:0]         recent_sq_sum;
  logic [19:0]         prior_sum;

  trend_result_t       expected_trends [$];

  task automatic take_sample(input logic [SAMPLE_W-1:0] height, output trend_result_t res);
    int unsigned         wp;
    int unsigned         mid;
    logic [SAMPLE_W-1:0] oldest;
    logic [SAMPLE_W-1:0] moving;
    logic [63:0]         spread;
    logic [63:0]         bound;
    wp     = line_ptr;
    mid    = (wp + WINDOW) % LINE_DEPTH;
    oldest = sample_line[wp];
    moving = sample_line[mid];
    // the middle sample leaves the recent window and joins the prior one
    prior_sum     = prior_sum + moving - oldest;
    recent_sum    = recent_sum + height - moving;
    recent_sq_sum = recent_sq_sum + height * height - moving * moving;
    sample_line[wp] = height;
    line_ptr = (wp + 1) % LINE_DEPTH;
    if (fill_count < LINE_DEPTH) fill_count++;
    res.held = HELD_W'(fill_count);
    if (fill_count < LINE_DEPTH) begin
      res.code = CODE_UNKNOWN;
    end else begin
      spread = 64'(WINDOW) * 64'(recent_sq_sum) - 64'(recent_sum) * 64'(recent_sum);
      bound  = 64'(var_limit) * 64'(WINDOW) * 64'(WINDOW - 1);
      if (spread > bound) begin
        res.code = CODE_INCONCLUSIVE;
      end else if (64'(prior_sum) <= 64'(mean_floor) * 64'(WINDOW)) begin
        res.code = CODE_UNKNOWN;
      end else if ((64'(recent_sum) << 16) < 64'(prior_sum) * 64'(drop_ratio)) begin
        res.code = CODE_FATIGUED;
      end else begin
        res.code = CODE_NORMAL;
      end
    end
  endtask

  always @(posedge clk) begin : track
    trend_result_t fresh;
    trend_result_t want;
    if (!rst_n) begin
      var_limit     = LIMIT_RESET;
      drop_ratio    = RATIO_RESET;
      mean_floor    = FLOOR_RESET;
      for (int i = 0; i < LINE_DEPTH; i++) sample_line[i] = '0;
      line_ptr      = 0;
      fill_count    = 0;
      recent_sum    = '0;
      recent_sq_sum = '0;
      prior_sum     = '0;
      fail_count    = 0;
      expected_trends.delete();
      pending_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_VARIANCE_LIMIT: var_limit  = cfg_pwdata[LIMIT_W-1:0];
          REG_DROP_RATIO:     drop_ratio = cfg_pwdata[RATIO_W-1:0];
          REG_MEAN_FLOOR:     mean_floor = cfg_pwdata[FLOOR_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        take_sample(in_mon.jump_height, fresh);
        expected_trends.push_back(fresh);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_trends.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          want = expected_trends.pop_front();
          if (out_mon.trend_code !== want.code) begin
            $error("trend_code expected %0d got %0d", want.code, out_mon.trend_code);
            fail_count++;
          end
          if (out_mon.samples_held !== want.held) begin
            $error("samples_held expected %0d got %0d", want.held, out_mon.samples_held);
            fail_count++;
          end
        end
      end
      pending_count <= expected_trends.size();
    end
  end

endmodule

// ===== test/tb_jump_fatigue_trend_classifier_core.sv =====
// testbench top for the trend classifier: clock, reset, stimulus, register phases and verdict
`timescale 1ns / 1ps
module tb_jump_fatigue_trend_classifier_core;
  import jftc_pkg::*;

  localparam int         IDLE_LIMIT      = 5000;
  localparam int         HOLD_OFF_CYCLES = 400;
  localparam int         HOLD_OFF_AFTER  = 600;
  localparam logic [1:0] REG_UNUSED      = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [APB_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int fail_count;
  int pending_count;
  int results_seen = 0;
  int idle_cycles  = 0;
  int burst_left   = 0;
  int heights_sent = 0;

  jftc_in_if  in_words ();
  jftc_out_if result_words ();

  jump_fatigue_trend_classifier_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_words),
    .out_word    (result_words),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  jftc_trend_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_words),
    .out_mon       (result_words),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (result_words.valid && result_words.ready) results_seen <= results_seen + 1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_words.valid && in_words.ready) ||
        (result_words.valid && result_words.ready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles < IDLE_LIMIT) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: stretches of different stall rates, plus one long hold-off
  initial begin : receiver
    int stretch;
    int busy_pct;
    bit held_off;
    stretch  = 0;
    busy_pct = 0;
    held_off = 1'b0;
    result_words.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        result_words.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if (stretch == 0) begin
        stretch = $urandom_range(5, 60);
        case ($urandom_range(0, 3))
          0:       busy_pct = 0;
          1:       busy_pct = 20;
          2:       busy_pct = 50;
          default: busy_pct = 90;
        endcase
      end
      result_words.ready <= ($urandom_range(0, 99) >= busy_pct);
      stretch--;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // sender: bursts of random length separated by random gaps
  task automatic offer_height(input logic [SAMPLE_W-1:0] h);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_words.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_words.valid       <= 1'b1;
    in_words.jump_height <= h;
    do @(posedge clk); while (!in_words.ready);
    burst_left--;
    heights_sent++;
  endtask

  // one training session: base height with drift and jitter, a little noise mixed in
  task automatic send_session();
    int len;
    int base;
    int drift;
    int amp;
    int h;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : $urandom_range(15, 60);
    case ($urandom_range(0, 9))
      0:       base = $urandom_range(60000, 65535);
      1:       base = $urandom_range(0, 40);
      default: base = $urandom_range(100, 5000);
    endcase
    case ($urandom_range(0, 4))
      0, 1:    drift = 0;
      2:       drift = -int'($urandom_range(1, 30));
      3:       drift = $urandom_range(1, 30);
      default: drift = -int'($urandom_range(50, 300));
    endcase
    case ($urandom_range(0, 3))
      0:       amp = 0;
      1:       amp = $urandom_range(1, 10);
      2:       amp = $urandom_range(10, 120);
      default: amp = $urandom_range(500, 5000);
    endcase
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 6) begin
        h = $urandom_range(0, 65535);
      end else begin
        h = base + drift * k + int'($urandom_range(0, 2 * amp)) - amp;
        if (h < 0) h = 0;
        else if (h > 65535) h = 65535;
      end
      offer_height(h[SAMPLE_W-1:0]);
    end
  endtask

  task automatic run_sessions(input int count);
    int target;
    target = heights_sent + count;
    while (heights_sent < target) send_session();
  endtask

  task automatic wait_for_results();
    in_words.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [LIMIT_W-1:0] limit;
    logic [RATIO_W-1:0] ratio;
    logic [FLOOR_W-1:0] floor;
    rst_n                <= 1'b0;
    in_words.valid       <= 1'b0;
    in_words.jump_height <= '0;
    cfg_psel             <= 1'b0;
    cfg_penable          <= 1'b0;
    cfg_pwrite           <= 1'b0;
    cfg_paddr            <= '0;
    cfg_pwdata           <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: filling, flat zero prior, then full-scale words for a wide spread
    repeat (20) offer_height('0);
    repeat (5) offer_height('1);
    run_sessions(300);
    wait_for_results();

    // tightest spread limit, full ratio
    cfg_write(REG_VARIANCE_LIMIT, '0);
    cfg_write(REG_DROP_RATIO, 32'h0000_FFFF);
    cfg_write(REG_MEAN_FLOOR, '0);
    run_sessions(300);
    wait_for_results();

    // widest spread limit, zero ratio, highest floor
    cfg_write(REG_VARIANCE_LIMIT, '1);
    cfg_write(REG_DROP_RATIO, '0);
    cfg_write(REG_MEAN_FLOOR, 32'h0000_FFFF);
    run_sessions(250);
    wait_for_results();

    cfg_write(REG_MEAN_FLOOR, '0);
    run_sessions(200);
    wait_for_results();

    for (int p = 0; p < 4; p++) begin
      case ($urandom_range(0, 2))
        0:       limit = $urandom_range(0, 8000);
        1:       limit = $urandom_range(0, 200000);
        default: limit = $urandom();
      endcase
      ratio = ($urandom_range(0, 1) == 0) ? $urandom_range(55000, 65535) : $urandom_range(0, 65535);
      floor = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3000) : $urandom_range(0, 65535);
      cfg_write(REG_VARIANCE_LIMIT, limit);
      cfg_write(REG_DROP_RATIO, {16'($urandom()), ratio});
      cfg_write(REG_MEAN_FLOOR, {16'($urandom()), floor});
      cfg_write(REG_UNUSED, $urandom());
      run_sessions(250);
      wait_for_results();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== jump_fatigue_trend_classifier_core.f =====
rtl/jftc_pkg.sv
rtl/jftc_ifs.sv
rtl/jftc_front.sv
rtl/jftc_queue.sv
rtl/jftc_back.sv
rtl/jump_fatigue_trend_classifier_core.sv
test/jftc_trend_checker.sv
test/tb_jump_fatigue_trend_classifier_core.sv
